FILE: rtl/core/graham_scan_convex_hull_top_macros.svh
// Assertion macros for the convex hull block.
// Used by graham_scan_convex_hull_top.sv; depends on nothing else.
`ifndef GRAHAM_SCAN_CONVEX_HULL_TOP_MACROS_SVH
`define GRAHAM_SCAN_CONVEX_HULL_TOP_MACROS_SVH

// same-cycle implication
`define GSCH_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GSCH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/gsch_pkg.sv
// Shared types and constants of the convex hull block.
// Command and status structs between controller and datapath; no dependencies.
package gsch_pkg;

   localparam int FIELD_BITS = 12;

   typedef enum logic [1:0] {PTS_I, PTS_ORD, PTS_STK, PTS_K} pts_sel_type;
   typedef enum logic [1:0] {STK_TOP2, STK_TOP1, STK_K} stk_sel_type;
   typedef enum logic {ORD_I, ORD_JM1} ord_sel_type;
   typedef enum logic [1:0] {MUL_CROSS, MUL_DU, MUL_DV} mul_op_type;
   typedef enum logic {OWR_U, OWR_V} ord_wsel_type;

   typedef struct packed {
      logic         load;
      logic         ld_u;
      logic         ld_v;
      logic         ld_o;
      logic         ld_vidx;
      logic         pv_upd;
      logic         clr_i;
      logic         inc_i;
      logic         set_j;
      logic         dec_j;
      logic         clr_m;
      logic         inc_m;
      logic         ord_we;
      ord_wsel_type ord_wsel;
      logic         stk_init;
      logic         stk_push;
      logic         stk_pop;
      logic         save_du;
      logic         clr_k;
      logic         inc_k;
      logic         out_load;
      logic         done_clr;
      pts_sel_type  pts_sel;
      ord_sel_type  ord_sel;
      stk_sel_type  stk_sel;
      mul_op_type   mul_op;
   } cmd_type;

   typedef struct packed {
      logic small_set;
      logic i_last;
      logic i_last_m;
      logic m_zero;
      logic j_zero;
      logic key_is_pv;
      logic cross_pos;
      logic cross_zero;
      logic du_lt;
      logic top_ge2;
      logic k_last;
   } sts_type;

endpackage

FILE: rtl/core/graham_scan_convex_hull_top.sv
// Flow: a point that does not end a set is only stored. An ending point of n points starts a pivot
// search, then an insertion sort of the other points by cross product about the pivot, then the
// stack scan with turn tests, then the emit of each vertex (straight from the store with two or fewer points).
// Throughput: one point per cycle while loading; the shared cross product unit and single-port
// store reads set the hull time. The input stalls until the last vertex transfer.
// Reset (synchronous, active high) empties the set, clears the flags and returns to idle.
`include "graham_scan_convex_hull_top_macros.svh"

module graham_scan_convex_hull_top #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gsch_pkg::FIELD_BITS-1:0] req_point_row,
   input  logic [gsch_pkg::FIELD_BITS-1:0] req_point_col,
   input  logic                            req_set_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gsch_pkg::FIELD_BITS-1:0] rsp_hull_row,
   output logic [gsch_pkg::FIELD_BITS-1:0] rsp_hull_col,
   output logic                            rsp_hull_last,
   output logic                            rsp_overflowed
);

   gsch_pkg::cmd_type cmd;
   gsch_pkg::sts_type sts;

   gsch_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_set_end (req_set_end),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   gsch_dp #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_point_row  (req_point_row),
      .req_point_col  (req_point_col),
      .rsp_hull_row   (rsp_hull_row),
      .rsp_hull_col   (rsp_hull_col),
      .rsp_hull_last  (rsp_hull_last),
      .rsp_overflowed (rsp_overflowed)
   );

   `GSCH_ASSERT_NOW(a_no_load_while_emit, clock, reset, !req_stall, !rsp_valid, "input open during emit")
   `GSCH_ASSERT_NEXT(a_end_starts_hull, clock, reset, req_valid && !req_stall && req_set_end, req_stall, "set end not taken")
   `GSCH_ASSERT_NEXT(a_last_reopens, clock, reset, rsp_valid && !rsp_stall && rsp_hull_last, !req_stall && !rsp_valid, "no return to idle")

endmodule

FILE: rtl/core/gsch_dp.sv
// Datapath: point store, sort order and hull stack memories, counters, cross product unit.
// Depends on gsch_pkg; driven by gsch_ctrl commands.
module gsch_dp #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gsch_pkg::cmd_type               cmd,
   output gsch_pkg::sts_type               sts,
   input  logic [gsch_pkg::FIELD_BITS-1:0] req_point_row,
   input  logic [gsch_pkg::FIELD_BITS-1:0] req_point_col,
   output logic [gsch_pkg::FIELD_BITS-1:0] rsp_hull_row,
   output logic [gsch_pkg::FIELD_BITS-1:0] rsp_hull_col,
   output logic                            rsp_hull_last,
   output logic                            rsp_overflowed
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int SB = (COORD_BITS < gsch_pkg::FIELD_BITS) ? COORD_BITS : gsch_pkg::FIELD_BITS;
   localparam int DW = SB + 1;
   localparam int PW = 2 * DW;
   localparam int RW = PW + 1;

   logic [2*SB-1:0] pts_mem [MAX_POINTS];
   logic [AW-1:0]   ord_mem [MAX_POINTS];
   logic [AW-1:0]   stk_mem [MAX_POINTS];

   logic [2*SB-1:0] pts_q_ff;
   logic [AW-1:0]   ord_q_ff;
   logic [AW-1:0]   stk_q_ff;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          drop_ff, drop_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] m_ff, m_in;
   logic [CW-1:0] top_ff, top_in;
   logic [CW-1:0] k_ff, k_in;

   logic [AW-1:0] pv_idx_ff, u_idx_ff, v_idx_ff;
   logic [SB-1:0] o_r_ff, o_c_ff, u_r_ff, u_c_ff, v_r_ff, v_c_ff;

   logic signed [PW-1:0] prod1_ff, prod2_ff;
   gsch_pkg::mul_op_type op_ff;
   logic signed [RW-1:0] res_ff, du_ff;

   logic [SB-1:0] q_r, q_c;
   logic          full;
   logic [CW-1:0] jm1, tm1, tm2, i_p1, k_p1, emit_cnt;
   logic [AW-1:0] pts_addr, ord_addr, stk_addr, stk_waddr, stk_wdata, ord_wdata;
   logic          pv_less;
   logic signed [DW-1:0] dur, duc, dvr, dvc, ma, mb, mc, md;

   assign q_r  = pts_q_ff[2*SB-1:SB];
   assign q_c  = pts_q_ff[SB-1:0];
   assign full = (cnt_ff == CW'(MAX_POINTS));
   assign jm1  = j_ff - CW'(1);
   assign tm1  = top_ff - CW'(1);
   assign tm2  = top_ff - CW'(2);
   assign i_p1 = i_ff + CW'(1);
   assign k_p1 = k_ff + CW'(1);
   assign emit_cnt = sts.small_set ? cnt_ff : top_ff;

   always_comb begin
      case (cmd.pts_sel)
         gsch_pkg::PTS_I:   pts_addr = i_ff[AW-1:0];
         gsch_pkg::PTS_ORD: pts_addr = ord_q_ff;
         gsch_pkg::PTS_STK: pts_addr = stk_q_ff;
         default:           pts_addr = k_ff[AW-1:0];
      endcase
      case (cmd.ord_sel)
         gsch_pkg::ORD_I: ord_addr = i_ff[AW-1:0];
         default:         ord_addr = jm1[AW-1:0];
      endcase
      case (cmd.stk_sel)
         gsch_pkg::STK_TOP2: stk_addr = tm2[AW-1:0];
         gsch_pkg::STK_TOP1: stk_addr = tm1[AW-1:0];
         default:            stk_addr = k_ff[AW-1:0];
      endcase
      ord_wdata = (cmd.ord_wsel == gsch_pkg::OWR_U) ? u_idx_ff : v_idx_ff;
      stk_waddr = cmd.stk_init ? AW'(0) : top_ff[AW-1:0];
      stk_wdata = cmd.stk_init ? pv_idx_ff : v_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         pts_mem[cnt_ff[AW-1:0]] <= {req_point_row[SB-1:0], req_point_col[SB-1:0]};
      end
      pts_q_ff <= pts_mem[pts_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.ord_we) begin
         ord_mem[j_ff[AW-1:0]] <= ord_wdata;
      end
      ord_q_ff <= ord_mem[ord_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.stk_init || cmd.stk_push) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_q_ff <= stk_mem[stk_addr];
   end

   // counters
   always_comb begin
      cnt_in  = cnt_ff;
      drop_in = drop_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      m_in    = m_ff;
      top_in  = top_ff;
      k_in    = k_ff;
      if (cmd.load) begin
         if (full) begin
            drop_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
      if (cmd.clr_i) begin
         i_in = '0;
      end else if (cmd.inc_i) begin
         i_in = i_p1;
      end
      if (cmd.set_j) begin
         j_in = m_ff;
      end else if (cmd.dec_j) begin
         j_in = jm1;
      end
      if (cmd.clr_m) begin
         m_in = '0;
      end else if (cmd.inc_m) begin
         m_in = m_ff + CW'(1);
      end
      if (cmd.stk_init) begin
         top_in = CW'(1);
      end else if (cmd.stk_push) begin
         top_in = top_ff + CW'(1);
      end else if (cmd.stk_pop) begin
         top_in = tm1;
      end
      if (cmd.clr_k) begin
         k_in = '0;
      end else if (cmd.inc_k) begin
         k_in = k_p1;
      end
      if (cmd.done_clr) begin
         cnt_in  = '0;
         drop_in = 1'b0;
         top_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         drop_ff <= 1'b0;
         i_ff    <= '0;
         j_ff    <= '0;
         m_ff    <= '0;
         top_ff  <= '0;
         k_ff    <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         drop_ff <= drop_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
         m_ff    <= m_in;
         top_ff  <= top_in;
         k_ff    <= k_in;
      end
   end

   // point registers
   assign pv_less = (i_ff == '0) || (q_r < o_r_ff) || ((q_r == o_r_ff) && (q_c < o_c_ff));

   always_ff @(posedge clock) begin
      if (cmd.ld_o || (cmd.pv_upd && pv_less)) begin
         o_r_ff <= q_r;
         o_c_ff <= q_c;
      end
      if (cmd.pv_upd && pv_less) begin
         pv_idx_ff <= i_ff[AW-1:0];
      end
      if (cmd.ld_u) begin
         u_r_ff   <= q_r;
         u_c_ff   <= q_c;
         u_idx_ff <= i_ff[AW-1:0];
      end
      if (cmd.ld_v) begin
         v_r_ff <= q_r;
         v_c_ff <= q_c;
      end
      if (cmd.ld_vidx) begin
         v_idx_ff <= ord_q_ff;
      end
   end

   // cross product and squared distance unit
   assign dur = $signed({1'b0, u_r_ff}) - $signed({1'b0, o_r_ff});
   assign duc = $signed({1'b0, u_c_ff}) - $signed({1'b0, o_c_ff});
   assign dvr = $signed({1'b0, v_r_ff}) - $signed({1'b0, o_r_ff});
   assign dvc = $signed({1'b0, v_c_ff}) - $signed({1'b0, o_c_ff});

   always_comb begin
      case (cmd.mul_op)
         gsch_pkg::MUL_DU: begin
            ma = dur; mb = dur; mc = duc; md = duc;
         end
         gsch_pkg::MUL_DV: begin
            ma = dvr; mb = dvr; mc = dvc; md = dvc;
         end
         default: begin
            ma = duc; mb = dvr; mc = dur; md = dvc;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod1_ff <= ma * mb;
      prod2_ff <= mc * md;
      op_ff    <= cmd.mul_op;
      if (op_ff == gsch_pkg::MUL_CROSS) begin
         res_ff <= RW'(prod1_ff) - RW'(prod2_ff);
      end else begin
         res_ff <= RW'(prod1_ff) + RW'(prod2_ff);
      end
      if (cmd.save_du) begin
         du_ff <= res_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_hull_row   <= gsch_pkg::FIELD_BITS'(q_r);
         rsp_hull_col   <= gsch_pkg::FIELD_BITS'(q_c);
         rsp_hull_last  <= sts.k_last;
         rsp_overflowed <= drop_ff;
      end
   end

   always_comb begin
      sts.small_set  = (cnt_ff <= CW'(2));
      sts.i_last     = (i_p1 == cnt_ff);
      sts.i_last_m   = (i_p1 == m_ff);
      sts.m_zero     = (m_ff == '0);
      sts.j_zero     = (j_ff == '0);
      sts.key_is_pv  = (u_r_ff == o_r_ff) && (u_c_ff == o_c_ff);
      sts.cross_pos  = !res_ff[RW-1] && (res_ff != '0);
      sts.cross_zero = (res_ff == '0);
      sts.du_lt      = (du_ff < res_ff);
      sts.top_ge2    = (top_ff >= CW'(2));
      sts.k_last     = (k_p1 == emit_cnt);
   end

endmodule

FILE: rtl/core/gsch_ctrl.sv
// Controller state machine: load, pivot search, insertion sort, stack scan, emit.
// Depends on gsch_pkg; commands gsch_dp.
module gsch_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_set_end,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  gsch_pkg::sts_type sts,
   output gsch_pkg::cmd_type cmd
);

   typedef enum logic [38:0] {
      IDLE       = 39'h1,
      START      = 39'h2,
      PV_RD      = 39'h4,
      PV_CMP     = 39'h8,
      KEY_RD     = 39'h10,
      KEY_LD     = 39'h20,
      KEY_CHK    = 39'h40,
      J_CHK      = 39'h80,
      ORD_RD     = 39'h100,
      ORD_DAT    = 39'h200,
      V_LD       = 39'h400,
      MUL1       = 39'h800,
      SUM1       = 39'h1000,
      CR_CHK     = 39'h2000,
      SHIFT      = 39'h4000,
      DU_MUL     = 39'h8000,
      DU_SUM     = 39'h10000,
      DU_SAVE    = 39'h20000,
      DV_SUM     = 39'h40000,
      DV_CHK     = 39'h80000,
      PLACE      = 39'h100000,
      SO_DONE    = 39'h200000,
      SC_ORD_RD  = 39'h400000,
      SC_ORD_DAT = 39'h800000,
      SC_P_LD    = 39'h1000000,
      SC_TOP_CHK = 39'h2000000,
      SC_S0_RD   = 39'h4000000,
      SC_S0_DAT  = 39'h8000000,
      SC_S0_LD   = 39'h10000000,
      SC_S1_LD   = 39'h20000000,
      SC_MUL     = 39'h40000000,
      SC_SUM     = 39'h80000000,
      SC_CHK     = 39'h100000000,
      PUSH       = 39'h200000000,
      EM_ADDR    = 39'h400000000,
      EM_STK     = 39'h800000000,
      EM_SADDR   = 39'h1000000000,
      EM_LD      = 39'h2000000000,
      EM_WAIT    = 39'h4000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = (state_ff == EM_WAIT);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.ord_wsel = gsch_pkg::OWR_U;
      cmd.pts_sel  = gsch_pkg::PTS_I;
      cmd.ord_sel  = gsch_pkg::ORD_I;
      cmd.stk_sel  = gsch_pkg::STK_K;
      cmd.mul_op   = gsch_pkg::MUL_CROSS;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_set_end) begin
                  state_in = START;
               end
            end
         end
         START: begin
            cmd.clr_k = 1'b1;
            cmd.clr_i = 1'b1;
            state_in  = sts.small_set ? EM_SADDR : PV_RD;
         end
         PV_RD: begin
            cmd.pts_sel = gsch_pkg::PTS_I;
            state_in    = PV_CMP;
         end
         PV_CMP: begin
            cmd.pv_upd = 1'b1;
            if (sts.i_last) begin
               cmd.clr_i = 1'b1;
               cmd.clr_m = 1'b1;
               state_in  = KEY_RD;
            end else begin
               cmd.inc_i = 1'b1;
               state_in  = PV_RD;
            end
         end
         KEY_RD: begin
            cmd.pts_sel = gsch_pkg::PTS_I;
            state_in    = KEY_LD;
         end
         KEY_LD: begin
            cmd.ld_u = 1'b1;
            state_in = KEY_CHK;
         end
         KEY_CHK: begin
            if (sts.key_is_pv) begin
               if (sts.i_last) begin
                  state_in = SO_DONE;
               end else begin
                  cmd.inc_i = 1'b1;
                  state_in  = KEY_RD;
               end
            end else begin
               cmd.set_j = 1'b1;
               state_in  = J_CHK;
            end
         end
         J_CHK: begin
            state_in = sts.j_zero ? PLACE : ORD_RD;
         end
         ORD_RD: begin
            cmd.ord_sel = gsch_pkg::ORD_JM1;
            state_in    = ORD_DAT;
         end
         ORD_DAT: begin
            cmd.ld_vidx = 1'b1;
            cmd.pts_sel = gsch_pkg::PTS_ORD;
            state_in    = V_LD;
         end
         V_LD: begin
            cmd.ld_v = 1'b1;
            state_in = MUL1;
         end
         MUL1: begin
            cmd.mul_op = gsch_pkg::MUL_CROSS;
            state_in   = SUM1;
         end
         SUM1: begin
            state_in = CR_CHK;
         end
         CR_CHK: begin
            if (sts.cross_pos) begin
               state_in = SHIFT;
            end else if (sts.cross_zero) begin
               state_in = DU_MUL;
            end else begin
               state_in = PLACE;
            end
         end
         SHIFT: begin
            cmd.ord_we   = 1'b1;
            cmd.ord_wsel = gsch_pkg::OWR_V;
            cmd.dec_j    = 1'b1;
            state_in     = J_CHK;
         end
         DU_MUL: begin
            cmd.mul_op = gsch_pkg::MUL_DU;
            state_in   = DU_SUM;
         end
         DU_SUM: begin
            state_in = DU_SAVE;
         end
         DU_SAVE: begin
            cmd.save_du = 1'b1;
            cmd.mul_op  = gsch_pkg::MUL_DV;
            state_in    = DV_SUM;
         end
         DV_SUM: begin
            state_in = DV_CHK;
         end
         DV_CHK: begin
            state_in = sts.du_lt ? SHIFT : PLACE;
         end
         PLACE: begin
            cmd.ord_we   = 1'b1;
            cmd.ord_wsel = gsch_pkg::OWR_U;
            cmd.inc_m    = 1'b1;
            if (sts.i_last) begin
               state_in = SO_DONE;
            end else begin
               cmd.inc_i = 1'b1;
               state_in  = KEY_RD;
            end
         end
         SO_DONE: begin
            cmd.stk_init = 1'b1;
            cmd.clr_i    = 1'b1;
            cmd.clr_k    = 1'b1;
            state_in     = sts.m_zero ? EM_ADDR : SC_ORD_RD;
         end
         SC_ORD_RD: begin
            cmd.ord_sel = gsch_pkg::ORD_I;
            state_in    = SC_ORD_DAT;
         end
         SC_ORD_DAT: begin
            cmd.ld_vidx = 1'b1;
            cmd.pts_sel = gsch_pkg::PTS_ORD;
            state_in    = SC_P_LD;
         end
         SC_P_LD: begin
            cmd.ld_v = 1'b1;
            state_in = SC_TOP_CHK;
         end
         SC_TOP_CHK: begin
            state_in = sts.top_ge2 ? SC_S0_RD : PUSH;
         end
         SC_S0_RD: begin
            cmd.stk_sel = gsch_pkg::STK_TOP2;
            state_in    = SC_S0_DAT;
         end
         SC_S0_DAT: begin
            cmd.pts_sel = gsch_pkg::PTS_STK;
            cmd.stk_sel = gsch_pkg::STK_TOP1;
            state_in    = SC_S0_LD;
         end
         SC_S0_LD: begin
            cmd.ld_o    = 1'b1;
            cmd.pts_sel = gsch_pkg::PTS_STK;
            state_in    = SC_S1_LD;
         end
         SC_S1_LD: begin
            cmd.ld_u = 1'b1;
            state_in = SC_MUL;
         end
         SC_MUL: begin
            cmd.mul_op = gsch_pkg::MUL_CROSS;
            state_in   = SC_SUM;
         end
         SC_SUM: begin
            state_in = SC_CHK;
         end
         SC_CHK: begin
            if (sts.cross_pos) begin
               state_in = PUSH;
            end else begin
               cmd.stk_pop = 1'b1;
               state_in    = SC_TOP_CHK;
            end
         end
         PUSH: begin
            cmd.stk_push = 1'b1;
            if (sts.i_last_m) begin
               cmd.clr_k = 1'b1;
               state_in  = EM_ADDR;
            end else begin
               cmd.inc_i = 1'b1;
               state_in  = SC_ORD_RD;
            end
         end
         EM_ADDR: begin
            cmd.stk_sel = gsch_pkg::STK_K;
            state_in    = EM_STK;
         end
         EM_STK: begin
            cmd.pts_sel = gsch_pkg::PTS_STK;
            state_in    = EM_LD;
         end
         EM_SADDR: begin
            cmd.pts_sel = gsch_pkg::PTS_K;
            state_in    = EM_LD;
         end
         EM_LD: begin
            cmd.out_load = 1'b1;
            state_in     = EM_WAIT;
         end
         EM_WAIT: begin
            if (!rsp_stall) begin
               if (sts.k_last) begin
                  cmd.done_clr = 1'b1;
                  state_in     = IDLE;
               end else begin
                  cmd.inc_k = 1'b1;
                  state_in  = sts.small_set ? EM_SADDR : EM_ADDR;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
